// ===== hdl/casv_pkg.sv =====
// Package for the chemical registry number check digit validator.
// Holds the request types, character classes, verdict codes and register indexes.
// No dependencies.
package casv_pkg;

  // One input request: a character byte and the end-of-string mark.
  typedef struct packed {
    logic [7:0] char_in;
    logic       is_last;
  } in_req_t;

  // One result request.
  typedef struct packed {
    logic [1:0] verdict;
    logic [3:0] correct_digit;
    logic [3:0] digit_weight_count;
  } out_req_t;

  typedef enum logic [1:0] {
    CLS_OTHER  = 2'd0,
    CLS_DIGIT  = 2'd1,
    CLS_HYPHEN = 2'd2
  } cls_t;

  localparam logic [1:0] VERDICT_BAD_FORMAT  = 2'd0;
  localparam logic [1:0] VERDICT_CONFORMANT  = 2'd1;
  localparam logic [1:0] VERDICT_WRONG_CHECK = 2'd2;

  localparam logic REG_MIN_LENGTH = 1'b0;
  localparam logic REG_MAX_LENGTH = 1'b1;

  localparam logic [3:0] MIN_LENGTH_RESET = 4'd7;
  localparam logic [3:0] MAX_LENGTH_RESET = 4'd12;

  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_HYPHEN = 8'h2d;

  localparam int HIST_DEPTH = 5;

  function automatic cls_t classify(input logic [7:0] c);
    cls_t r;
    r = CLS_OTHER;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      r = CLS_DIGIT;
    end else if (c == CHAR_HYPHEN) begin
      r = CLS_HYPHEN;
    end
    return r;
  endfunction

  // Sum of two decimal digits, reduced mod 10.
  function automatic logic [3:0] add_mod10(input logic [3:0] a, input logic [3:0] b);
    logic [4:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 5'd10) begin
      s = s - 5'd10;
    end
    return s[3:0];
  endfunction

endpackage

// ===== hdl/cas_number_check_digit_validator.sv =====
// Top level of the chemical registry number check digit validator.
// Uses casv_pkg for request types, character classes and codes.
//
// Usage:
// Characters of a candidate number enter on the in channel (in_valid, in_stall,
// in_data) one request per cycle while not stalled, left to right; is_last marks the final one.
// Each character but the last updates the length count, a five-deep class history
// and sticky error flags, and each digit also updates running mod-10 sums. Only the
// last character yields a result request on the out channel (out_valid, out_stall,
// out_data), which holds the verdict, the correct check digit and the digit weight count.
// The result is registered and appears in the cycle after the last character is taken.
// The block takes one character per cycle while in_stall is low, set by the single state update stage.
// A waiting result sits in the output register; the block stalls its input
// only while that register is full and the receiver stalls it.
// Reset clears the per-string state and the output valid flag and restores the
// length limits to 7 and 12. The user must write the limits through cfg_write,
// cfg_index and cfg_data only while the block is idle; the block does not enforce it.
module cas_number_check_digit_validator
  import casv_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_data,
  input  logic     cfg_write,
  input  logic     cfg_index,
  input  logic [3:0] cfg_data
);

  logic [3:0] min_length;
  logic [3:0] max_length;

  logic [3:0] char_count;
  logic       length_overflow;
  logic       prefix_bad;
  cls_t       class_history [HIST_DEPTH];
  logic [3:0] digit_sum;
  logic [3:0] weighted_sum;
  logic [3:0] digit_count;

  logic       in_accept;
  cls_t       cls;
  logic [3:0] digit_sum_next;
  logic [3:0] weighted_sum_next;
  logic [4:0] str_len;
  logic       form_ok;
  out_req_t   result;

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  assign cls               = classify(in_data.char_in);
  assign digit_sum_next    = add_mod10(digit_sum, in_data.char_in[3:0]);
  assign weighted_sum_next = add_mod10(weighted_sum, digit_sum_next);

  // Length of the string including the last character, saturating at 16.
  assign str_len = length_overflow ? 5'd16 : ({1'b0, char_count} + 5'd1);

  always_comb begin
    form_ok = !length_overflow
      && str_len >= {1'b0, min_length} && str_len <= {1'b0, max_length}
      && char_count >= 4'd4
      && cls == CLS_DIGIT
      && class_history[0] == CLS_HYPHEN
      && class_history[1] == CLS_DIGIT
      && class_history[2] == CLS_DIGIT
      && class_history[3] == CLS_HYPHEN
      && !prefix_bad
      && (char_count < 4'd5 || class_history[4] == CLS_DIGIT);
    if (form_ok) begin
      result.verdict = (in_data.char_in[3:0] == weighted_sum) ?
                       VERDICT_CONFORMANT : VERDICT_WRONG_CHECK;
      result.correct_digit      = weighted_sum;
      result.digit_weight_count = digit_count + 4'd1;
    end else begin
      result.verdict            = VERDICT_BAD_FORMAT;
      result.correct_digit      = 4'd0;
      result.digit_weight_count = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= MIN_LENGTH_RESET;
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MIN_LENGTH: min_length <= cfg_data;
        REG_MAX_LENGTH: max_length <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count      <= 4'd0;
      length_overflow <= 1'b0;
      prefix_bad      <= 1'b0;
      digit_sum       <= 4'd0;
      weighted_sum    <= 4'd0;
      digit_count     <= 4'd0;
      for (int k = 0; k < HIST_DEPTH; k++) begin
        class_history[k] <= CLS_OTHER;
      end
    end else if (in_accept) begin
      if (in_data.is_last) begin
        // The string is finished: start the next one from a clean state.
        char_count      <= 4'd0;
        length_overflow <= 1'b0;
        prefix_bad      <= 1'b0;
        digit_sum       <= 4'd0;
        weighted_sum    <= 4'd0;
        digit_count     <= 4'd0;
        for (int k = 0; k < HIST_DEPTH; k++) begin
          class_history[k] <= CLS_OTHER;
        end
      end else begin
        if (cls == CLS_DIGIT) begin
          digit_sum    <= digit_sum_next;
          weighted_sum <= weighted_sum_next;
          if (digit_count != 4'd15) begin
            digit_count <= digit_count + 4'd1;
          end
        end
        // The character leaving the history belongs to the leading run.
        if (char_count >= 4'd5 && class_history[HIST_DEPTH-1] != CLS_DIGIT) begin
          prefix_bad <= 1'b1;
        end
        for (int k = HIST_DEPTH - 1; k > 0; k--) begin
          class_history[k] <= class_history[k-1];
        end
        class_history[0] <= cls;
        if (char_count == 4'd15) begin
          length_overflow <= 1'b1;
        end else begin
          char_count <= char_count + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= in_data.is_last;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_data.is_last) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.verdict == VERDICT_BAD_FORMAT
                   || out_data.verdict == VERDICT_CONFORMANT
                   || out_data.verdict == VERDICT_WRONG_CHECK))
    else $error("result carries an undefined verdict code");

  a_bad_format_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.verdict == VERDICT_BAD_FORMAT)
      |-> (out_data.correct_digit == 4'd0 && out_data.digit_weight_count == 4'd0))
    else $error("bad-format result carries nonzero digit fields");

  a_no_result_mid_string: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !in_data.is_last && !out_valid) |=> !out_valid)
    else $error("result produced for a character that is not the last");

  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_data.is_last)
      |=> (char_count == 4'd0 && digit_count == 4'd0 && !prefix_bad && out_valid))
    else $error("string state not cleared or result missing after last character");
`endif

endmodule
